>>> rtl/core/fsbra_pkg.sv
// Shared constants, action codes and types for the free-slot bitmap run allocator.
// No dependencies; imported by the scan unit and the top level.
`default_nettype none

package fsbra_pkg;

  // Bitmap geometry and limits
  localparam int WORD_BITS        = 16;
  localparam int BITMAP_WORDS_DEF = 256;
  localparam int MAX_RUN_DEF      = 32;
  localparam int START_LIMIT      = 8191;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int POS_W  = 13;
  localparam int CNT_W  = 6;
  // Run counter: holds a carried run below the request plus one word
  localparam int RUN_W  = 7;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 16;

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_MARK_FREE = 2'd0,
    ACT_MARK_USED = 2'd1,
    ACT_ALLOCATE  = 2'd2,
    ACT_NONE      = 2'd3
  } fsbra_action_e;

  // Per-word search result handed from the scan unit to the control
  typedef struct packed {
    logic             hit;
    logic [3:0]       bit_idx;
    logic [RUN_W-1:0] run_out;
  } fsbra_hit_t;

endpackage

`default_nettype wire

>>> rtl/core/fsbra_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies; holds the free bitmap words.
`default_nettype none

module fsbra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word and register the read word at the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/fsbra_scan.sv
// Single-word run search: finds where a free run first reaches the request.
// Depends on fsbra_pkg for widths and the result struct.
`default_nettype none

module fsbra_scan
  import fsbra_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word_i,
  input  wire logic [RUN_W-1:0]     run_in_i,
  input  wire logic [CNT_W-1:0]     count_i,
  output fsbra_hit_t                result_o
);

  logic [WORD_BITS-1:0] hit_vec;
  logic                 zero_seen;
  logic [3:0]           hz;
  logic [RUN_W-1:0]     run_i;

  // Run length ending at each bit, from the highest used slot at or below it
  always_comb begin
    hit_vec   = '0;
    zero_seen = 1'b0;
    hz        = '0;
    run_i     = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      zero_seen = 1'b0;
      hz        = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j <= i && !word_i[j]) begin
          zero_seen = 1'b1;
          hz        = 4'(j);
        end
      end
      if (zero_seen) begin
        run_i = RUN_W'(i) - RUN_W'(hz);
      end else begin
        run_i = run_in_i + RUN_W'(i + 1);
      end
      hit_vec[i] = (run_i >= {1'b0, count_i});
    end
  end

  // Pick the lowest bit that completes the run; carry the tail otherwise
  always_comb begin
    result_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        result_o.hit     = 1'b1;
        result_o.bit_idx = 4'(i);
      end
    end
    if (zero_seen) begin
      result_o.run_out = RUN_W'(WORD_BITS - 1) - RUN_W'(hz);
    end else begin
      result_o.run_out = run_in_i + RUN_W'(WORD_BITS);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/free_slot_bitmap_run_allocator_core.sv
// Top level of the free-slot bitmap run allocator: control, bitmap RAM, scan unit.
// Depends on fsbra_pkg, fsbra_ram and fsbra_scan.
//
// Usage:
//   Requests enter on the s_axis channel (action, slot_position, run_length) and
//   each produces exactly one response on the m_axis channel (run_start, found,
//   out_of_range). One request is in work at a time.
//   Each request ends in the response state, which loads the output register and
//   returns to idle, where the next request can be taken.
//   Mark free / mark used: read the word, write it back, respond.
//   Zero position, out of range, unknown action and rejected run lengths: respond directly.
//   Allocate: the scan reads one bitmap word per cycle from word 0 until a run
//   completes or the last word fails; on success each word that the run covers
//   is read and written back before the response.
//   Reset: the bitmap RAM is cleared by a pass over all BITMAP_WORDS words, one
//   word a cycle; s_axis_tready_o stays low until it finishes.
//   Stall: the response sits in an output register; a new request is accepted
//   while it waits, and the next response is held until the receiver takes it.
`default_nettype none

module free_slot_bitmap_run_allocator_core
  import fsbra_pkg::*;
#(
  parameter int BITMAP_WORDS = BITMAP_WORDS_DEF,
  parameter int MAX_RUN      = MAX_RUN_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Request: [1:0] action, [14:2] slot_position, [20:15] run_length, [23:21] zero
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  // Response: [12:0] run_start, [13] found, [14] out_of_range, [15] zero
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic      [OUT_W-1:0] m_axis_tdata_o
);

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  // Controller states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_CRD   = 3'd4;
  localparam logic [2:0] ST_CWR   = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    w_q, w_d;
  logic [3:0]       bit_q, bit_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [AW-1:0]    sw_q, sw_d, ew_q, ew_d;
  logic [3:0]       sb_q, sb_d, eb_q, eb_d;
  logic [POS_W-1:0] res_start_q, res_start_d;
  logic             res_found_q, res_found_d;
  logic             res_oor_q, res_oor_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  // Request fields
  fsbra_action_e    in_action;
  logic [POS_W-1:0] in_pos;
  logic [CNT_W-1:0] in_count;
  logic             in_fire;
  logic [31:0]      pos_m1;
  logic [AW-1:0]    mark_word;

  // Scan results
  fsbra_hit_t       scan_res;
  logic [31:0]      end_idx;
  logic [31:0]      start_pos;
  logic [31:0]      first_idx;
  logic [WORD_BITS-1:0] clr_mask;
  logic [WORD_BITS-1:0] mark_mask;

  assign in_action = fsbra_action_e'(s_axis_tdata_i[1:0]);
  assign in_pos    = s_axis_tdata_i[14:2];
  assign in_count  = s_axis_tdata_i[20:15];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign pos_m1    = 32'(in_pos) - 32'd1;
  assign mark_word = pos_m1[AW+3:4];

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  fsbra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  fsbra_scan u_scan (
    .word_i   (ram_rdata),
    .run_in_i (run_q),
    .count_i  (cnt_q),
    .result_o (scan_res)
  );

  // Locate the run that the current word completes
  assign end_idx   = 32'({w_q, scan_res.bit_idx});
  assign start_pos = end_idx + 32'd2 - 32'(cnt_q);
  assign first_idx = start_pos - 32'd1;

  // Bits of the word under clear that belong to the allocated run
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      clr_mask[k] = ((w_q != sw_q) || (4'(k) >= sb_q)) &&
                    ((w_q != ew_q) || (4'(k) <= eb_q));
    end
  end

  assign mark_mask = WORD_BITS'(1) << bit_q;

  // RAM access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = w_q;
    ram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_addr = (in_action == ACT_ALLOCATE) ? '0 : mark_word;
      end
      ST_SCAN: begin
        ram_addr = w_q + AW'(1);
      end
      ST_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = (act_q == ACT_MARK_FREE) ? (ram_rdata | mark_mask)
                                             : (ram_rdata & ~mark_mask);
      end
      ST_CRD: begin
        ram_addr = w_q;
      end
      ST_CWR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~clr_mask;
      end
      ST_RESP: begin
        ram_addr = w_q;
      end
      default: begin
        ram_addr = w_q;
      end
    endcase
  end

  // Sequence one request at a time
  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    bit_d       = bit_q;
    act_d       = act_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    sw_d        = sw_q;
    sb_d        = sb_q;
    ew_d        = ew_q;
    eb_d        = eb_q;
    res_start_d = res_start_q;
    res_found_d = res_found_q;
    res_oor_d   = res_oor_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // Drop the response once taken
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        w_d = w_q + AW'(1);
        if (w_q == AW'(BITMAP_WORDS - 1)) begin
          w_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          act_d       = in_action;
          cnt_d       = in_count;
          run_d       = '0;
          res_start_d = '0;
          res_found_d = 1'b0;
          res_oor_d   = 1'b0;
          state_d     = ST_RESP;
          case (in_action) inside
            ACT_MARK_FREE, ACT_MARK_USED: begin
              if (in_pos != '0) begin
                if (32'(in_pos) > 32'(BITMAP_WORDS * WORD_BITS)) begin
                  res_oor_d = 1'b1;
                end else begin
                  w_d     = mark_word;
                  bit_d   = pos_m1[3:0];
                  state_d = ST_MARK;
                end
              end
            end
            ACT_ALLOCATE: begin
              if (in_count != '0 && 32'(in_count) <= 32'(MAX_RUN)) begin
                w_d     = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_res.hit) begin
          if (start_pos > 32'(START_LIMIT)) begin
            state_d = ST_RESP;
          end else begin
            res_start_d = start_pos[POS_W-1:0];
            res_found_d = 1'b1;
            sw_d        = first_idx[AW+3:4];
            sb_d        = first_idx[3:0];
            ew_d        = w_q;
            eb_d        = scan_res.bit_idx;
            w_d         = first_idx[AW+3:4];
            state_d     = ST_CRD;
          end
        end else if (w_q == AW'(BITMAP_WORDS - 1)) begin
          state_d = ST_RESP;
        end else begin
          w_d   = w_q + AW'(1);
          run_d = scan_res.run_out;
        end
      end
      ST_MARK: begin
        state_d = ST_RESP;
      end
      ST_CRD: begin
        state_d = ST_CWR;
      end
      ST_CWR: begin
        if (w_q == ew_q) begin
          state_d = ST_RESP;
        end else begin
          w_d     = w_q + AW'(1);
          state_d = ST_CRD;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, res_oor_q, res_found_q, res_start_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bit_q       <= bit_d;
    act_q       <= act_d;
    cnt_q       <= cnt_d;
    run_q       <= run_d;
    sw_q        <= sw_d;
    sb_q        <= sb_d;
    ew_q        <= ew_d;
    eb_q        <= eb_d;
    res_start_q <= res_start_d;
    res_found_q <= res_found_d;
    res_oor_q   <= res_oor_d;
    out_data_q  <= out_data_d;
  end

`ifndef SYNTH
  // A successful allocation always reports a nonzero start
  a_found_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[13] |-> m_axis_tdata_o[12:0] != '0)
    else $error("found response with zero run_start");

  // Allocation and out-of-range never both flag
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[13] && m_axis_tdata_o[14]))
    else $error("found and out_of_range set together");

  // A run clear stays within the span found by the scan
  a_clear_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CWR) |-> (w_q >= sw_q) && (w_q <= ew_q))
    else $error("run clear outside allocated span");

  // A new response is loaded only when the previous one was taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) && out_valid_q && !m_axis_tready_i |=> (state_q == ST_RESP))
    else $error("response overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> tb/sv/free_slot_bitmap_run_allocator_core_tb.sv
// Self-checking testbench for free_slot_bitmap_run_allocator_core: a directed
// pass, then random mark/allocate sequences checked against a bitmap predictor.
// Depends on fsbra_pkg and the core RTL only.
`timescale 1ns / 100ps

module free_slot_bitmap_run_allocator_core_tb;
  import fsbra_pkg::*;

  localparam int SLOT_CAP    = BITMAP_WORDS_DEF * WORD_BITS;
  localparam int RANDOM_REQS = 550;

  typedef struct {
    fsbra_action_e         action;
    logic [POS_W-1:0]      pos;
    logic [CNT_W-1:0]      count;
    bit                    drain_first;  // hold until every response is back
  } slot_req_t;

  typedef struct {
    logic [POS_W-1:0] run_start;
    logic             found;
    logic             out_of_range;
  } slot_rsp_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             req_valid;
  logic [IN_W-1:0]  req_data;
  logic             rsp_ready;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;

  // Predictor bitmap: a set bit marks a free slot
  logic [WORD_BITS-1:0] slot_words [BITMAP_WORDS_DEF];

  slot_req_t pending_reqs[$];
  slot_rsp_t expected_rsps[$];
  slot_req_t cur_req;

  int issued_cnt;
  int received_cnt;
  int mismatch_cnt;
  int counted_reqs;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_cycle;
  int mark_cnt;
  int oor_cnt;
  int alloc_hit_cnt;
  int alloc_miss_cnt;
  int noop_cnt;

  free_slot_bitmap_run_allocator_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (req_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (rsp_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Apply one request to the bitmap and return the response it should give
  function automatic slot_rsp_t predict_slot_response(input slot_req_t r);
    slot_rsp_t rsp;
    int        run;
    int        start_idx;
    rsp = '{default: '0};
    case (r.action)
      ACT_MARK_FREE, ACT_MARK_USED: begin
        if (r.pos != 0) begin
          if (r.pos > SLOT_CAP)
            rsp.out_of_range = 1'b1;
          else
            slot_words[(r.pos - 1) / WORD_BITS][(r.pos - 1) % WORD_BITS] =
              (r.action == ACT_MARK_FREE);
        end
      end
      ACT_ALLOCATE: begin
        if (r.count != 0 && r.count <= MAX_RUN_DEF) begin
          run = 0;
          for (int idx = 0; idx < SLOT_CAP; idx++) begin
            if (!slot_words[idx / WORD_BITS][idx % WORD_BITS]) begin
              run = 0;
            end else begin
              run++;
              if (run == r.count) begin
                start_idx = idx + 1 - r.count;
                // only starts that fit the response field count
                if (start_idx + 1 <= START_LIMIT) begin
                  for (int k = 0; k < r.count; k++)
                    slot_words[(start_idx + k) / WORD_BITS][(start_idx + k) % WORD_BITS] = 1'b0;
                  rsp.run_start = start_idx + 1;
                  rsp.found     = 1'b1;
                end
                return rsp;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Queue one request; no-op requests do not count toward the random total
  task automatic add_req(input fsbra_action_e a, input int pos, input int cnt,
                         input bit drain = 1'b0);
    slot_req_t r;
    r.action      = a;
    r.pos         = pos;
    r.count       = cnt;
    r.drain_first = drain;
    pending_reqs.push_back(r);
    if (a == ACT_ALLOCATE || (a != ACT_NONE && pos != 0))
      counted_reqs++;
  endtask

  // Request driver: bursts with random gaps, fed from pending_reqs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid  <= 1'b0;
      req_data   <= '0;
      issued_cnt = 0;
      burst_left = 0;
      gap_left   = 0;
      mark_cnt = 0; oor_cnt = 0; alloc_hit_cnt = 0; alloc_miss_cnt = 0; noop_cnt = 0;
      foreach (slot_words[i]) slot_words[i] = '0;
    end else begin
      // record the accepted request and its expected response
      if (req_valid && s_axis_tready_o) begin
        slot_rsp_t exp_rsp;
        exp_rsp = predict_slot_response(cur_req);
        expected_rsps.push_back(exp_rsp);
        issued_cnt++;
        case (cur_req.action)
          ACT_ALLOCATE: begin
            if (exp_rsp.found) alloc_hit_cnt++;
            else alloc_miss_cnt++;
          end
          ACT_NONE: noop_cnt++;
          default: begin
            if (cur_req.pos == 0) noop_cnt++;
            else mark_cnt++;
            if (exp_rsp.out_of_range) oor_cnt++;
          end
        endcase
      end
      // advance to the next request, a gap, or hold for a drain
      if (!req_valid || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain_first || issued_cnt == received_cnt)) begin
          cur_req = pending_reqs.pop_front();
          req_valid <= 1'b1;
          req_data  <= {3'b000, cur_req.count, cur_req.pos, cur_req.action};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: stall on a changing pattern, check each response
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready    <= 1'b0;
      received_cnt <= 0;
      stall_mode   = 0;
      stall_cycle  = 0;
    end else begin
      if (m_axis_tvalid_o && rsp_ready) begin
        slot_rsp_t exp_rsp;
        received_cnt <= received_cnt + 1;
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("response 0x%h with no request outstanding",
                                    m_axis_tdata_o));
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (m_axis_tdata_o[POS_W-1:0] !== exp_rsp.run_start)
            report_mismatch($sformatf("run_start expected %0d got %0d",
                                      exp_rsp.run_start, m_axis_tdata_o[POS_W-1:0]));
          if (m_axis_tdata_o[POS_W] !== exp_rsp.found)
            report_mismatch($sformatf("found expected %0b got %0b",
                                      exp_rsp.found, m_axis_tdata_o[POS_W]));
          if (m_axis_tdata_o[POS_W+1] !== exp_rsp.out_of_range)
            report_mismatch($sformatf("out_of_range expected %0b got %0b",
                                      exp_rsp.out_of_range, m_axis_tdata_o[POS_W+1]));
        end
      end
      stall_cycle++;
      if (stall_cycle % 128 == 0)
        stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= stall_cycle[0];
        2:       rsp_ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ready <= (stall_cycle % 8 == 0);
      endcase
    end
  end

  // Stimulus and end of run
  initial begin
    int kind;
    int base;
    int len;
    int pick;
    mismatch_cnt = 0;
    counted_reqs = 0;

    // directed: rejects, no-ops, range edges, word-crossing run
    add_req(ACT_ALLOCATE, 0, 0);
    add_req(ACT_ALLOCATE, 0, 1);          // nothing free yet
    add_req(ACT_MARK_FREE, 0, 63);
    add_req(ACT_MARK_USED, 0, 0);
    add_req(ACT_NONE, 8191, 63);
    add_req(ACT_MARK_FREE, SLOT_CAP, 0);
    add_req(ACT_MARK_FREE, SLOT_CAP + 1, 0);
    add_req(ACT_MARK_USED, 8191, 0);
    add_req(ACT_ALLOCATE, 8191, 63);
    add_req(ACT_ALLOCATE, 0, MAX_RUN_DEF + 1);
    add_req(ACT_ALLOCATE, 0, 1);          // takes the last slot
    for (int p = 15; p <= 18; p++)
      add_req(ACT_MARK_FREE, p, 0);
    add_req(ACT_ALLOCATE, 0, 5);          // too long, bitmap stays
    add_req(ACT_ALLOCATE, 0, 4);          // crosses words 0 and 1
    add_req(ACT_MARK_FREE, 100, 0);
    add_req(ACT_MARK_USED, 100, 0);
    add_req(ACT_ALLOCATE, 0, 1);
    add_req(ACT_MARK_FREE, 1, 0);
    add_req(ACT_MARK_USED, SLOT_CAP, 0);
    add_req(ACT_ALLOCATE, 0, 1);

    // random: mostly free-then-allocate sequences, the rest noise
    counted_reqs = 0;
    add_req(ACT_ALLOCATE, $urandom_range(0, 8191), MAX_RUN_DEF, 1'b1);
    while (counted_reqs < RANDOM_REQS) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len  = $urandom_range(1, MAX_RUN_DEF);
        base = ($urandom_range(0, 6) != 0) ? $urandom_range(1, 300)
                                           : $urandom_range(1, SLOT_CAP - len + 1);
        add_req(ACT_MARK_FREE, base, $urandom_range(0, 63), ($urandom_range(0, 19) == 0));
        for (int p = base + 1; p < base + len; p++)
          add_req(ACT_MARK_FREE, p, $urandom_range(0, 63));
        // break the run now and then
        if ($urandom_range(0, 4) == 0)
          add_req(ACT_MARK_USED, base + $urandom_range(0, len - 1), $urandom_range(0, 63));
        pick = ($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len);
        add_req(ACT_ALLOCATE, $urandom_range(0, 8191), pick);
        if ($urandom_range(0, 3) == 0)
          add_req(ACT_ALLOCATE, $urandom_range(0, 8191), $urandom_range(1, MAX_RUN_DEF));
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 6))
          add_req(ACT_MARK_FREE, $urandom_range(1, 400), $urandom_range(0, 63));
        add_req(ACT_ALLOCATE, $urandom_range(0, 8191), $urandom_range(1, 4));
      end else if (kind < 80) begin
        add_req(ACT_ALLOCATE, $urandom_range(0, 8191), $urandom_range(0, 63));
      end else if (kind < 90) begin
        add_req(ACT_MARK_USED, ($urandom_range(0, 3) == 0) ? $urandom_range(1, SLOT_CAP)
                                                            : $urandom_range(1, 400),
                $urandom_range(0, 63));
      end else if (kind < 95) begin
        add_req(fsbra_action_e'($urandom_range(0, 1)), $urandom_range(SLOT_CAP + 1, 8191),
                $urandom_range(0, 63));
      end else begin
        add_req(fsbra_action_e'($urandom_range(0, 3)), $urandom_range(0, 8191),
                $urandom_range(0, 63));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every request to go out and every response to return
    while (pending_reqs.size() != 0 || req_valid || issued_cnt != received_cnt)
      @(negedge clk_i);
    repeat (BITMAP_WORDS_DEF + 16) @(negedge clk_i);

    if (expected_rsps.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));

    $display("Covered %0d requests: %0d marks (%0d out of range), %0d no-ops,",
             issued_cnt, mark_cnt, oor_cnt, noop_cnt);
    $display("  %0d allocations found a run, %0d were refused", alloc_hit_cnt,
             alloc_miss_cnt);
    if (mismatch_cnt == 0)
      $display("free_slot_bitmap_run_allocator_core test passed");
    else
      $display("free_slot_bitmap_run_allocator_core test failed");
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #1500000;
    $display("free_slot_bitmap_run_allocator_core test failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fsbra_pkg.sv
rtl/core/fsbra_ram.sv
rtl/core/fsbra_scan.sv
rtl/core/free_slot_bitmap_run_allocator_core.sv
tb/sv/free_slot_bitmap_run_allocator_core_tb.sv
